### src/lbs_pkg.sv
// Shared types and constants for the LED blink sequencer.
`default_nettype none

package lbs_pkg;

    localparam int unsigned FIELD_W   = 16;
    localparam int unsigned APB_DW    = 32;
    localparam int unsigned APB_AW    = 3;
    localparam int unsigned TICK_W    = 8;

    localparam logic [TICK_W-1:0] TICK_MS_RESET = 8'd30;

    typedef enum logic {
        REG_TICK_MS = 1'b0,
        REG_NONE    = 1'b1
    } t_reg_idx;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_LOAD = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_START = 2'd1,
        PH_LIT   = 2'd2,
        PH_DARK  = 2'd3
    } t_phase;

    typedef struct packed {
        logic               opcode;
        logic [FIELD_W-1:0] on_time;
        logic [FIELD_W-1:0] dark_time;
        logic [FIELD_W-1:0] repeat_count;
    } t_item;

    typedef struct packed {
        logic led_lit;
        logic pattern_active;
    } t_result;

endpackage

`default_nettype wire

### src/lbs_if.sv
// Valid/ready channel interfaces for command/tick items and results.
`default_nettype none

interface lbs_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [15:0] on_time;
    logic [15:0] dark_time;
    logic [15:0] repeat_count;

    modport source (output valid, opcode, on_time, dark_time, repeat_count, input ready);
    modport sink   (input valid, opcode, on_time, dark_time, repeat_count, output ready);
endinterface

interface lbs_out_if;
    logic valid;
    logic ready;
    logic led_lit;
    logic pattern_active;

    modport source (output valid, led_lit, pattern_active, input ready);
    modport sink   (input valid, led_lit, pattern_active, output ready);
endinterface

`default_nettype wire

### src/led_blink_sequencer.sv
// LED blink sequencer top level: input register, pattern core, result register.
//
// Items arrive on i_in (valid/ready). opcode LOAD latches on_time, dark_time
// and repeat_count and arms a restart; opcode TICK starts an armed pattern
// and then advances it by tick_ms milliseconds. Every item yields exactly
// one result on o_out: led_lit and pattern_active after that item.
// tick_ms is set through the APB port at byte address 0 (reset value 30).
// An accepted item sits in the input register until the result register
// can load; that edge updates the pattern state and loads the result
// register, and the result is then presented on o_out.
// Throughput: one item per cycle unless o_out stalls; the update is a
// single add and compare, so one tick or command is retired every cycle.
// Reset (synchronous, active low) clears the pattern to idle with the LED
// off and empties both registers. When o_out stalls, the result register
// holds, the input register keeps its item, and i_in.ready drops only
// once both are full.
`default_nettype none

module led_blink_sequencer #(
    parameter int unsigned TIME_BITS = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    lbs_in_if.sink                          i_in,
    lbs_out_if.source                       o_out,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [lbs_pkg::APB_AW-1:0] paddr,
    input  wire logic [lbs_pkg::APB_DW-1:0] pwdata,
    output logic      [lbs_pkg::APB_DW-1:0] prdata,
    output logic                            pready
);
    import lbs_pkg::*;

    logic              r_s1_valid;
    t_item             r_s1_item;
    logic              r_out_valid;
    t_result           r_out;

    logic              w_out_load;
    logic              w_s1_fire;
    logic              w_in_fire;
    t_result           w_result;
    logic [TICK_W-1:0] w_tick_ms;

    lbs_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_tick_ms (w_tick_ms)
    );

    assign w_out_load = !r_out_valid || o_out.ready;
    assign w_s1_fire  = r_s1_valid && w_out_load;
    assign i_in.ready = !r_s1_valid || w_out_load;
    assign w_in_fire  = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_s1_item.opcode       <= i_in.opcode;
            r_s1_item.on_time      <= i_in.on_time;
            r_s1_item.dark_time    <= i_in.dark_time;
            r_s1_item.repeat_count <= i_in.repeat_count;
        end
    end

    lbs_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (w_s1_fire),
        .i_item    (r_s1_item),
        .i_tick_ms (w_tick_ms),
        .o_result  (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_fire) begin
            r_out <= w_result;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.led_lit        = r_out.led_lit;
    assign o_out.pattern_active = r_out.pattern_active;

endmodule

`default_nettype wire

### src/lbs_regs.sv
// APB configuration register block holding tick_ms.
`default_nettype none

module lbs_regs (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [lbs_pkg::APB_AW-1:0] paddr,
    input  wire logic [lbs_pkg::APB_DW-1:0] pwdata,
    output logic      [lbs_pkg::APB_DW-1:0] prdata,
    output logic                            pready,
    output logic      [lbs_pkg::TICK_W-1:0] o_tick_ms
);
    import lbs_pkg::*;

    logic [TICK_W-1:0] r_tick_ms;
    t_reg_idx          w_idx;
    logic              w_wr;

    assign w_idx  = t_reg_idx'(paddr[APB_AW-1]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_ms <= TICK_MS_RESET;
        end else if (w_wr && (w_idx == REG_TICK_MS)) begin
            r_tick_ms <= pwdata[TICK_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        case (w_idx)
            REG_TICK_MS: prdata = APB_DW'(r_tick_ms);
            default:     prdata = '0;
        endcase
    end

    assign o_tick_ms = r_tick_ms;

endmodule

`default_nettype wire

### src/lbs_core.sv
// Pattern state machine: applies one command or tick per transfer.
`default_nettype none

module lbs_core #(
    parameter int unsigned TIME_BITS = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_fire,
    input  wire lbs_pkg::t_item             i_item,
    input  wire logic [lbs_pkg::TICK_W-1:0] i_tick_ms,
    output lbs_pkg::t_result                o_result
);
    import lbs_pkg::*;

    // elapsed time can creep upward when the period is shorter than two ticks
    localparam int unsigned EW = TIME_BITS + 32;

    t_phase               r_phase,   n_phase;
    logic                 r_pending, n_pending;
    logic [EW-1:0]        r_elapsed, n_elapsed;
    logic [TIME_BITS-1:0] r_lit,     n_lit;
    logic [TIME_BITS-1:0] r_dark,    n_dark;
    logic [FIELD_W-1:0]   r_periods, n_periods;
    logic                 r_led,     n_led;

    t_phase               w_phase;
    logic [EW-1:0]        w_sum;
    logic [EW-1:0]        w_period;
    logic [31:0]          w_on32;
    logic [31:0]          w_off32;

    assign w_on32   = 32'(i_item.on_time);
    assign w_off32  = 32'(i_item.dark_time);
    assign w_sum    = r_elapsed + EW'(i_tick_ms);
    assign w_period = EW'(r_lit) + EW'(r_dark);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_pending <= 1'b0;
            r_elapsed <= '0;
            r_lit     <= '0;
            r_dark    <= '0;
            r_periods <= '0;
            r_led     <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_pending <= n_pending;
            r_elapsed <= n_elapsed;
            r_lit     <= n_lit;
            r_dark    <= n_dark;
            r_periods <= n_periods;
            r_led     <= n_led;
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_pending = r_pending;
        n_elapsed = r_elapsed;
        n_lit     = r_lit;
        n_dark    = r_dark;
        n_periods = r_periods;
        n_led     = r_led;
        w_phase   = r_pending ? PH_START : r_phase;
        if (i_fire) begin
            if (t_opcode'(i_item.opcode) == OP_LOAD) begin
                n_pending = 1'b1;
                n_lit     = w_on32[TIME_BITS-1:0];
                n_dark    = w_off32[TIME_BITS-1:0];
                n_periods = i_item.repeat_count;
            end else begin
                n_pending = 1'b0;
                case (w_phase)
                    PH_START: begin
                        n_phase = PH_IDLE;
                        if (r_lit != '0) begin
                            n_led = 1'b1;
                            if (r_dark != '0) begin
                                n_elapsed = '0;
                                n_phase   = PH_LIT;
                            end
                        end else begin
                            n_led = 1'b0;
                        end
                    end
                    PH_LIT: begin
                        n_elapsed = w_sum;
                        if (w_sum >= EW'(r_lit)) begin
                            n_led   = 1'b0;
                            n_phase = PH_DARK;
                        end
                    end
                    PH_DARK: begin
                        n_elapsed = w_sum;
                        if (w_sum >= w_period) begin
                            n_elapsed = w_sum - w_period;
                            if (r_periods == FIELD_W'(1)) begin
                                n_led   = 1'b0;
                                n_phase = PH_IDLE;
                            end else begin
                                n_led   = 1'b1;
                                n_phase = PH_LIT;
                                if (r_periods != '0) begin
                                    n_periods = r_periods - FIELD_W'(1);
                                end
                            end
                        end
                    end
                    default: n_phase = w_phase;
                endcase
            end
        end
    end

    assign o_result.led_lit        = n_led;
    assign o_result.pattern_active = (n_phase == PH_LIT) || (n_phase == PH_DARK);

endmodule

`default_nettype wire

### bench/led_blink_sequencer_tb.sv
// Testbench for the LED blink sequencer: directed and random items, predicted results checked in order.
`timescale 1ns / 1ps

module led_blink_sequencer_tb;
    import lbs_pkg::*;

    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int MAX_REPORTS    = 10;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    lbs_in_if  in_if ();
    lbs_out_if out_if ();

    led_blink_sequencer u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #4 i_clk = ~i_clk;

    // blink state mirror
    logic [TICK_W-1:0]  tick_ms_cfg = TICK_MS_RESET;
    t_phase             blink_phase = PH_IDLE;
    bit                 restart_armed = 1'b0;
    longint unsigned    elapsed_ms = 0;
    logic [FIELD_W-1:0] lit_ms = '0;
    logic [FIELD_W-1:0] dark_ms = '0;
    logic [FIELD_W-1:0] periods_left = '0;
    bit                 led_on = 1'b0;

    t_result predicted_leds[$];
    int      fail_count = 0;
    bit      gaps_on = 1'b0;
    bit      stalls_on = 1'b0;
    int      burst_left = 0;

    function automatic t_result predict_blink(input t_item it);
        t_result         r;
        longint unsigned blink_period;
        blink_period = longint'(lit_ms) + longint'(dark_ms);
        if (it.opcode == OP_LOAD) begin
            restart_armed = 1'b1;
            lit_ms        = it.on_time;
            dark_ms       = it.dark_time;
            periods_left  = it.repeat_count;
        end else begin
            if (restart_armed) begin
                restart_armed = 1'b0;
                blink_phase   = PH_START;
            end
            case (blink_phase)
                PH_START: begin
                    if (lit_ms != 0) begin
                        led_on = 1'b1;
                        if (dark_ms != 0) begin
                            elapsed_ms  = 0;
                            blink_phase = PH_LIT;
                        end else begin
                            blink_phase = PH_IDLE;
                        end
                    end else begin
                        led_on      = 1'b0;
                        blink_phase = PH_IDLE;
                    end
                end
                PH_LIT: begin
                    elapsed_ms += tick_ms_cfg;
                    if (elapsed_ms >= lit_ms) begin
                        led_on      = 1'b0;
                        blink_phase = PH_DARK;
                    end
                end
                PH_DARK: begin
                    elapsed_ms += tick_ms_cfg;
                    if (elapsed_ms >= blink_period) begin
                        elapsed_ms -= blink_period;
                        if (periods_left == 1) begin
                            led_on      = 1'b0;
                            blink_phase = PH_IDLE;
                        end else begin
                            led_on = 1'b1;
                            if (periods_left != 0)
                                periods_left -= 1'b1;
                            blink_phase = PH_LIT;
                        end
                    end
                end
                default: ;
            endcase
        end
        r.led_lit        = led_on;
        r.pattern_active = (blink_phase == PH_LIT) || (blink_phase == PH_DARK);
        return r;
    endfunction

    task automatic flag_error(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    always @(posedge i_clk) begin : track_items
        t_item it;
        if (i_rst_n && in_if.valid && in_if.ready) begin
            it.opcode       = in_if.opcode;
            it.on_time      = in_if.on_time;
            it.dark_time    = in_if.dark_time;
            it.repeat_count = in_if.repeat_count;
            predicted_leds.push_back(predict_blink(it));
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (predicted_leds.size() == 0) begin
                flag_error($sformatf("unexpected result led_lit=%0b pattern_active=%0b",
                                     out_if.led_lit, out_if.pattern_active));
            end else begin
                want = predicted_leds.pop_front();
                if (out_if.led_lit !== want.led_lit)
                    flag_error($sformatf("led_lit expected %0b got %0b",
                                         want.led_lit, out_if.led_lit));
                if (out_if.pattern_active !== want.pattern_active)
                    flag_error($sformatf("pattern_active expected %0b got %0b",
                                         want.pattern_active, out_if.pattern_active));
            end
        end
    end

    initial begin : result_stalls
        int hold;
        hold = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                out_if.ready <= 1'b0;
                hold--;
            end else if (stalls_on && $urandom_range(0, 5) == 0) begin
                hold = $urandom_range(0, 7);
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                stuck = 0;
            else
                stuck++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic t_item make_item(input t_opcode op, input logic [FIELD_W-1:0] on_ms,
                                        input logic [FIELD_W-1:0] off_ms,
                                        input logic [FIELD_W-1:0] reps);
        t_item it;
        it.opcode       = op;
        it.on_time      = on_ms;
        it.dark_time    = off_ms;
        it.repeat_count = reps;
        return it;
    endfunction

    function automatic t_item tick_item();
        return make_item(OP_TICK, 16'($urandom), 16'($urandom), 16'($urandom));
    endfunction

    function automatic logic [FIELD_W-1:0] pattern_time();
        int pick;
        pick = $urandom_range(0, 15);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return 16'($urandom);
        return 16'($urandom_range(1, 4 * int'(tick_ms_cfg)));
    endfunction

    function automatic t_item random_pattern();
        int                 pick;
        logic [FIELD_W-1:0] reps;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            reps = 16'($urandom_range(0, 4));
        else if (pick == 6)
            reps = 16'($urandom);
        else
            reps = 16'd1;
        return make_item(OP_LOAD, pattern_time(), pattern_time(), reps);
    endfunction

    // one transfer on the item channel, with optional sender bursts and gaps
    task automatic send_item(input t_item it);
        int gap;
        if (gaps_on && burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap        = $urandom_range(0, 6);
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        in_if.valid        <= 1'b1;
        in_if.opcode       <= it.opcode;
        in_if.on_time      <= it.on_time;
        in_if.dark_time    <= it.dark_time;
        in_if.repeat_count <= it.repeat_count;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        if (burst_left > 0)
            burst_left--;
    endtask

    task automatic settle();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (predicted_leds.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_tick_ms(input logic [TICK_W-1:0] ms);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(4 * int'(REG_TICK_MS));
        pwdata  <= APB_DW'(ms);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tick_ms_cfg = ms;
    endtask

    task automatic test_idle_ticks();
        send_item(make_item(OP_TICK, '1, '1, '1));
        send_item(make_item(OP_TICK, '0, '0, '0));
    endtask

    task automatic test_solid_levels();
        send_item(make_item(OP_LOAD, 16'd0, 16'hFFFF, 16'hFFFF));
        send_item(tick_item());
        send_item(make_item(OP_LOAD, 16'hFFFF, 16'd0, 16'd0));
        send_item(tick_item());
        send_item(tick_item());
        send_item(make_item(OP_LOAD, 16'd0, 16'd0, 16'd0));
    endtask

    // two periods at the default tick, then idle dark
    task automatic test_counted_blink();
        send_item(make_item(OP_LOAD, 16'd30, 16'd30, 16'd2));
        repeat (6) send_item(tick_item());
    endtask

    // new command lands mid blink, restart waits for the next tick
    task automatic test_restart_mid_blink();
        send_item(make_item(OP_LOAD, 16'd40, 16'd40, 16'd0));
        send_item(tick_item());
        send_item(make_item(OP_LOAD, 16'd90, 16'd30, 16'd1));
        send_item(tick_item());
        send_item(tick_item());
    endtask

    // tick far longer than a period: excess carried over each period
    task automatic test_large_tick();
        write_tick_ms(8'd255);
        send_item(make_item(OP_LOAD, 16'd1, 16'd1, 16'd3));
        repeat (7) send_item(tick_item());
    endtask

    task automatic test_random_traffic(input int n_items, input bit use_gaps,
                                       input bit use_stalls);
        int sent;
        int run_len;
        sent      = 0;
        gaps_on   = use_gaps;
        stalls_on = use_stalls;
        while (sent < n_items) begin
            if ($urandom_range(0, 6) == 0) begin
                send_item(make_item($urandom_range(0, 1) ? OP_LOAD : OP_TICK,
                                    16'($urandom), 16'($urandom), 16'($urandom)));
                sent++;
            end else begin
                send_item(random_pattern());
                sent++;
                run_len = $urandom_range(1, 30);
                repeat (run_len) begin
                    if ($urandom_range(0, 40) == 0)
                        send_item(random_pattern());
                    else
                        send_item(tick_item());
                    sent++;
                end
            end
        end
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
    endtask

    initial begin
        i_rst_n            <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        in_if.valid        <= 1'b0;
        in_if.opcode       <= OP_TICK;
        in_if.on_time      <= '0;
        in_if.dark_time    <= '0;
        in_if.repeat_count <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_ticks();
        test_solid_levels();
        test_counted_blink();
        test_restart_mid_blink();
        test_large_tick();

        test_random_traffic(256, 1'b0, 1'b0);
        write_tick_ms(8'd1);
        test_random_traffic(256, 1'b1, 1'b1);
        write_tick_ms(8'($urandom_range(2, 254)));
        test_random_traffic(256, 1'b1, 1'b0);
        write_tick_ms(8'($urandom_range(1, 255)));
        test_random_traffic(256, 1'b0, 1'b1);

        settle();
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
